FILE: rtl/btpg_pkg.sv
// Shared types and constants for the bench tooth pattern generator.
`default_nettype none

package btpg_pkg;

   localparam int CsrAddrBits = 5;

   localparam logic OP_ARM  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] MODE_ITER  = 2'd0;
   localparam logic [1:0] MODE_TOOTH = 2'd1;

   localparam logic [2:0] REG_PATTERN_MODE     = 3'd0;
   localparam logic [2:0] REG_EVENTS_PER_CYCLE = 3'd1;
   localparam logic [2:0] REG_FIXED_PERIOD     = 3'd2;
   localparam logic [2:0] REG_CYCLE_COUNT      = 3'd3;
   localparam logic [2:0] REG_MISSING_TEETH    = 3'd4;
   localparam logic [2:0] REG_TOOTH_DELAY      = 3'd5;

   typedef struct packed {
      logic [1:0]  pattern_mode;
      logic [7:0]  events_per_cycle;
      logic [15:0] fixed_period;
      logic [15:0] cycle_count;
      logic [7:0]  missing_teeth;
      logic [15:0] tooth_delay;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  event_counter;
      logic [15:0] cycles_left;
      logic        running;
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] edge_time;
      logic [15:0] live_period;
   } req_type;

   typedef struct packed {
      logic [15:0] cam_width;
      logic [15:0] cam_wait;
      logic        cam_fire;
      logic [15:0] tooth_width;
      logic [15:0] tooth_wait;
      logic        tooth_fire;
      logic        run_active;
      logic [7:0]  event_index;
      logic [15:0] next_compare;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/bench_tooth_pattern_generator.sv
// Top level of the bench tooth pattern generator.
//
// Transactions enter on the req_ stream: tuser carries the opcode (arm or
// compare-match tick) and tdata carries the edge time and the live period.
// Every transaction produces exactly one result transaction on the rsp_
// stream, in order. An arm clears the event counter, loads the cycle count
// and starts a run; each tick during a run advances the pattern and returns
// the next compare time and any crank tooth or cam pulse to schedule, or ends it.
// The transaction is held in an input register, the run state and the result
// are worked out combinationally, and the result lands in an output register:
// a result is offered once its transaction has passed the input register and
// the output register, and one transaction per cycle is sustained while the
// receiver does not stall. When the receiver stalls, the output
// register holds its result and the input register fills; req_tready then
// drops until the output register is taken. Reset empties both registers,
// stops the run and loads the registers of the csr_ port with their defaults.
// The user must write configuration through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none

module bench_tooth_pattern_generator #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: edge_time [15:0], live_period [31:16]
   input  wire logic [31:0]                     req_tdata,
   // tuser: opcode [0]
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: next_compare [15:0], event_index [23:16], run_active [24],
   // tooth_fire [25], tooth_wait [41:26], tooth_width [57:42], cam_fire [58],
   // cam_wait [74:59], cam_width [90:75], zero fill [95:91]
   output logic      [95:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [btpg_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic      [31:0]                     csr_prdata,
   output logic                                 csr_pready
);
   import btpg_pkg::*;

   cfg_type   cfg;
   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   btpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btpg_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .cfg        (cfg),
      .state      (state_ff),
      .req        (req_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff.opcode      <= req_tuser;
         req_ff.edge_time   <= req_tdata[15:0];
         req_ff.live_period <= req_tdata[31:16];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_state_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("run state changed without a transaction");

   a_arm_result : assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.opcode == OP_ARM |=>
         rsp_tvalid && rsp_ff.run_active && rsp_ff.event_index == 8'd0 && state_ff.running)
      else $error("arm did not start a run");

   a_idle_tick : assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.opcode == OP_TICK && !state_ff.running |=>
         !rsp_ff.run_active && !state_ff.running && !rsp_ff.tooth_fire && !rsp_ff.cam_fire)
      else $error("tick while idle produced activity");

   a_quiet_pulses : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_ff.tooth_fire || (rsp_ff.tooth_wait == 16'd0 && rsp_ff.tooth_width == 16'd0)) &&
         (rsp_ff.cam_fire || (rsp_ff.cam_wait == 16'd0 && rsp_ff.cam_width == 16'd0)))
      else $error("pulse fields set without a pulse");

   a_stopped_result : assert property (@(posedge clock) disable iff (reset)
      advance && !state_in.running |=> !rsp_ff.run_active)
      else $error("result claims an active run after it stopped");
`endif

endmodule

`default_nettype wire

FILE: rtl/btpg_csr.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module btpg_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [btpg_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic      [31:0]                     csr_prdata,
   output logic                                 csr_pready,
   output btpg_pkg::cfg_type                    cfg
);
   import btpg_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  reg_index;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_PATTERN_MODE:     cfg_in.pattern_mode     = csr_pwdata[1:0];
            REG_EVENTS_PER_CYCLE: cfg_in.events_per_cycle = csr_pwdata[7:0];
            REG_FIXED_PERIOD:     cfg_in.fixed_period     = csr_pwdata[15:0];
            REG_CYCLE_COUNT:      cfg_in.cycle_count      = csr_pwdata[15:0];
            REG_MISSING_TEETH:    cfg_in.missing_teeth    = csr_pwdata[7:0];
            REG_TOOTH_DELAY:      cfg_in.tooth_delay      = csr_pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_MODE:     csr_prdata = {30'd0, cfg_ff.pattern_mode};
         REG_EVENTS_PER_CYCLE: csr_prdata = {24'd0, cfg_ff.events_per_cycle};
         REG_FIXED_PERIOD:     csr_prdata = {16'd0, cfg_ff.fixed_period};
         REG_CYCLE_COUNT:      csr_prdata = {16'd0, cfg_ff.cycle_count};
         REG_MISSING_TEETH:    csr_prdata = {24'd0, cfg_ff.missing_teeth};
         REG_TOOTH_DELAY:      csr_prdata = {16'd0, cfg_ff.tooth_delay};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_mode     <= MODE_ITER;
         cfg_ff.events_per_cycle <= 8'd24;
         cfg_ff.fixed_period     <= 16'd1000;
         cfg_ff.cycle_count      <= 16'd1;
         cfg_ff.missing_teeth    <= 8'd1;
         cfg_ff.tooth_delay      <= 16'd66;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/btpg_core.sv
// Per-transaction logic: next run state and the result fields.
`default_nettype none

module btpg_core #(
   parameter int TIMER_BITS = 16
) (
   input  wire btpg_pkg::cfg_type   cfg,
   input  wire btpg_pkg::state_type state,
   input  wire btpg_pkg::req_type   req,
   output btpg_pkg::state_type      state_next,
   output btpg_pkg::rsp_type        rsp
);
   import btpg_pkg::*;

   localparam logic [15:0] TimerMask =
      (TIMER_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << TIMER_BITS) - 33'd1);

   logic [15:0] period;
   logic [15:0] sum;
   logic [7:0]  count_inc;
   logic        cycle_wrap;
   logic [7:0]  count_next;
   logic [15:0] cycles_dec;
   logic [7:0]  half;
   logic [7:0]  pos;
   logic [14:0] single;
   logic [23:0] wide;
   logic        before_gap;
   logic [13:0] quarter;

   always_comb begin
      period     = (cfg.pattern_mode == MODE_ITER) ? cfg.fixed_period : req.live_period;
      sum        = req.edge_time + period;
      count_inc  = state.event_counter + 8'd1;
      cycle_wrap = (count_inc == cfg.events_per_cycle);
      count_next = cycle_wrap ? 8'd0 : count_inc;
      cycles_dec = cycle_wrap ? state.cycles_left - 16'd1 : state.cycles_left;
      half       = {1'b0, cfg.events_per_cycle[7:1]};
      pos        = (count_next >= half) ? count_next - half : count_next;
      single     = req.live_period[15:1];
      wide       = 24'(single) * 24'({1'b0, cfg.missing_teeth} + 9'd1);
      before_gap = ((half != 8'd0) && (count_next == half - 8'd1)) ||
                   ((cfg.events_per_cycle != 8'd0) &&
                    (count_next == cfg.events_per_cycle - 8'd1));
      quarter    = req.live_period[15:2];

      state_next           = state;
      rsp                  = '0;
      rsp.next_compare     = req.edge_time & TimerMask;
      rsp.event_index      = state.event_counter;

      if (req.opcode == OP_ARM) begin
         state_next.event_counter = 8'd0;
         state_next.cycles_left   = cfg.cycle_count;
         state_next.running       = 1'b1;
         rsp.event_index          = 8'd0;
         rsp.run_active           = 1'b1;
         if (cfg.pattern_mode == MODE_ITER || cfg.pattern_mode == MODE_TOOTH) begin
            rsp.next_compare = sum & TimerMask;
         end
      end else if (!state.running) begin
         rsp.run_active = 1'b0;
      end else if (cfg.pattern_mode != MODE_ITER && cfg.pattern_mode != MODE_TOOTH) begin
         state_next.running = 1'b0;
      end else if (cycle_wrap && cycles_dec == 16'd0) begin
         state_next.event_counter = 8'd0;
         state_next.cycles_left   = cycles_dec;
         state_next.running       = 1'b0;
         rsp.event_index          = 8'd0;
      end else begin
         state_next.event_counter = count_next;
         state_next.cycles_left   = cycles_dec;
         rsp.next_compare         = sum & TimerMask;
         rsp.event_index          = count_next;
         rsp.run_active           = 1'b1;
         if (cfg.pattern_mode == MODE_TOOTH) begin
            if (count_next == 8'd0) begin
               rsp.cam_fire  = 1'b1;
               rsp.cam_wait  = {2'b0, quarter} + {1'b0, quarter, 1'b0};
               rsp.cam_width = req.live_period;
            end
            if (pos >= cfg.missing_teeth) begin
               rsp.tooth_fire  = 1'b1;
               rsp.tooth_wait  = cfg.tooth_delay;
               rsp.tooth_width = {1'b0, single};
               if (before_gap) begin
                  rsp.tooth_width = (wide > 24'd65535) ? 16'hFFFF : wide[15:0];
               end
            end
         end
      end
   end

endmodule

`default_nettype wire
